@@ sv/esg_pkg.sv @@
// Shared types, constants and tables for the ellipse segment generator.
`timescale 1ns / 1ps

package esg_pkg;

    localparam int NUM_REGS = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SIDES_W = 7;
    localparam int COORD_W = 32;
    localparam int TRIG_W = 34;
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int DEF_MAX_SIDES = 64;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam logic [TRIG_W-1:0] CORDIC_GAIN = 34'd652032874;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_SIDES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAJOR_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAJOR_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAJOR_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MINOR_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MINOR_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MINOR_Z = 3'd6;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        logic start;
        logic [COORD_W-1:0] phase;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        trig_t sin_val;
        trig_t cos_val;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0: val = 32'd536870912;
            5'd1: val = 32'd316933406;
            5'd2: val = 32'd167458907;
            5'd3: val = 32'd85004756;
            5'd4: val = 32'd42667331;
            5'd5: val = 32'd21354465;
            5'd6: val = 32'd10680862;
            5'd7: val = 32'd5340245;
            5'd8: val = 32'd2670163;
            5'd9: val = 32'd1335087;
            5'd10: val = 32'd667544;
            5'd11: val = 32'd333772;
            5'd12: val = 32'd166886;
            5'd13: val = 32'd83443;
            5'd14: val = 32'd41722;
            5'd15: val = 32'd20861;
            5'd16: val = 32'd10430;
            5'd17: val = 32'd5215;
            5'd18: val = 32'd2608;
            5'd19: val = 32'd1304;
            5'd20: val = 32'd652;
            5'd21: val = 32'd326;
            5'd22: val = 32'd163;
            5'd23: val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

@@ sv/esg_cordic.sv @@
// Iterative rotation-mode CORDIC producing sine and cosine in Q4.30.
`timescale 1ns / 1ps

module esg_cordic #(
    parameter int CORDIC_STEPS = esg_pkg::DEF_CORDIC_STEPS
) (
    input  logic clk,
    input  logic rst_n,
    input  esg_pkg::cordic_req_t req,
    output esg_pkg::cordic_rsp_t rsp
);
    import esg_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
    localparam int Z_W = 33;

    logic busy_reg;
    logic done_reg;
    logic [STEP_W-1:0] step_reg;
    trig_t x_reg;
    trig_t y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [1:0] quad_reg;
    trig_t xs;
    trig_t ys;
    logic signed [Z_W-1:0] ang;
    trig_t c_raw;
    trig_t s_raw;

    function automatic trig_t clamp_unit(input trig_t v);
        trig_t one;
        one = trig_t'(35'sd1 <<< 30);
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        ang = Z_W'(signed'({1'b0, atan_entry(5'(step_reg))}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start &&
                        (step_reg == STEP_W'(CORDIC_STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    busy_reg <= 1'b0;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= Z_W'({3'b000, req.phase[29:0]});
            quad_reg <= req.phase[31:30];
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                c_raw = x_reg;
                s_raw = y_reg;
            end
            2'd1:
            begin
                c_raw = -y_reg;
                s_raw = x_reg;
            end
            2'd2:
            begin
                c_raw = -x_reg;
                s_raw = -y_reg;
            end
            default:
            begin
                c_raw = y_reg;
                s_raw = -x_reg;
            end
        endcase
        rsp.done = done_reg;
        rsp.sin_val = clamp_unit(s_raw);
        rsp.cos_val = clamp_unit(c_raw);
    end

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("CORDIC done without a run");
    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("CORDIC done while busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < STEP_W'(CORDIC_STEPS))
        else $error("CORDIC step out of range");

endmodule

@@ sv/ellipse_segment_generator_top.sv @@
// Top level: registers, phase divider, sequencer, shared multiplier and output stage.
//
//  Channel   Signals                                  Direction
//  config    cfg_we, cfg_index, cfg_data              in
//  start     start_valid, start_stall, start_run      in (start_stall out)
//  segment   seg_valid, seg_stall, seg_* last_segment out (seg_stall in)
//
// Each side computes the phase (load, 40 quotient bits, hand-off), then sine
// and cosine on the CORDIC, then six products on one 32x34 multiplier, and
// then presents one segment at the output stage.
// A start transaction with start_run = 0 is accepted and yields nothing.
// Reset restores the register defaults and idles the sequencer.
// A stalled segment holds the sequencer until it is taken.
`timescale 1ns / 1ps

module ellipse_segment_generator_top #(
    parameter int MAX_SIDES = esg_pkg::DEF_MAX_SIDES,
    parameter int CORDIC_STEPS = esg_pkg::DEF_CORDIC_STEPS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [esg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [esg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic start_valid,
    output logic start_stall,
    input  logic start_run,
    output logic seg_valid,
    input  logic seg_stall,
    output logic signed [31:0] seg_start_x,
    output logic signed [31:0] seg_start_y,
    output logic signed [31:0] seg_start_z,
    output logic signed [31:0] seg_end_x,
    output logic signed [31:0] seg_end_y,
    output logic signed [31:0] seg_end_z,
    output logic last_segment
);
    import esg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV = 3'd1;
    localparam logic [2:0] ST_TRIG = 3'd2;
    localparam logic [2:0] ST_MUL = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    localparam logic [SIDES_W-1:0] MAX_N = SIDES_W'(MAX_SIDES);
    localparam int DIV_W = 40;

    logic [2:0] state_reg;
    logic [SIDES_W-1:0] num_sides_reg;
    logic signed [31:0] major_reg [3];
    logic signed [31:0] minor_reg [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] end_reg [3];
    logic [SIDES_W-1:0] n_reg;
    logic [SIDES_W-1:0] k_reg;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0] div_cnt_reg;
    trig_t sin_reg;
    trig_t cos_reg;
    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic [SIDES_W-1:0] n_eff;
    logic [DIV_W-1:0] rem_sh;
    logic [DIV_W-1:0] rem_sub;
    logic signed [66:0] acc_sh;
    logic signed [31:0] sat_val;
    logic start_acc;
    cordic_req_t creq;
    cordic_rsp_t crsp;

    assign start_stall = (state_reg != ST_IDLE);
    assign start_acc = start_valid && !start_stall;
    assign n_eff = (num_sides_reg > MAX_N) ? MAX_N : num_sides_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sides_reg <= SIDES_W'(16);
            major_reg[0] <= 32'sd65536;
            major_reg[1] <= '0;
            major_reg[2] <= '0;
            minor_reg[0] <= '0;
            minor_reg[1] <= 32'sd65536;
            minor_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_SIDES: num_sides_reg <= cfg_data[SIDES_W-1:0];
                REG_MAJOR_X: major_reg[0] <= cfg_data;
                REG_MAJOR_Y: major_reg[1] <= cfg_data;
                REG_MAJOR_Z: major_reg[2] <= cfg_data;
                REG_MINOR_X: minor_reg[0] <= cfg_data;
                REG_MINOR_Y: minor_reg[1] <= cfg_data;
                REG_MINOR_Z: minor_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Restoring divider: one quotient bit of (k * 2^32 + n/2) / n per cycle.
    assign rem_sh = {rem_reg[DIV_W-2:0], num_reg[DIV_W-1]};
    assign rem_sub = rem_sh - DIV_W'(n_reg);

    assign acc_sh = acc_reg >>> 30;
    assign sat_val = (acc_sh > 67'sd2147483647) ? 32'sh7FFFFFFF :
                     (acc_sh < -67'sd2147483648) ? 32'sh80000000 : acc_sh[31:0];

    assign creq.start = (state_reg == ST_DIV) && (div_cnt_reg == 6'd41);
    assign creq.phase = quo_reg;

    esg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk),
        .rst_n(rst_n),
        .req(creq),
        .rsp(crsp)
    );

    logic [3:0] mseq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_valid <= 1'b0;
            k_reg <= '0;
            n_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_acc && start_run && n_eff != '0)
                    begin
                        n_reg <= n_eff;
                        k_reg <= SIDES_W'(1);
                        div_cnt_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == 6'd41)
                        state_reg <= ST_TRIG;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                ST_TRIG:
                begin
                    if (crsp.done)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (mseq_reg == 4'd7)
                    begin
                        seg_valid <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!seg_stall)
                    begin
                        seg_valid <= 1'b0;
                        if (last_segment)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            div_cnt_reg <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers; the multiply sequence has a product register ahead of
    // the accumulator.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start_acc)
        begin
            prev_reg[0] <= major_reg[0];
            prev_reg[1] <= major_reg[1];
            prev_reg[2] <= major_reg[2];
        end
        if (state_reg == ST_DIV)
        begin
            if (div_cnt_reg == 6'd0)
            begin
                num_reg <= DIV_W'(({33'd0, k_reg} << 32) + 40'(n_reg >> 1));
                rem_reg <= '0;
            end
            else if (div_cnt_reg != 6'd41)
            begin
                num_reg <= {num_reg[DIV_W-2:0], 1'b0};
                if (!rem_sub[DIV_W-1])
                begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
        end
        if (state_reg == ST_TRIG && crsp.done)
        begin
            sin_reg <= crsp.sin_val;
            cos_reg <= crsp.cos_val;
        end
        if (state_reg == ST_OUT && !seg_stall)
        begin
            prev_reg[0] <= end_reg[0];
            prev_reg[1] <= end_reg[1];
            prev_reg[2] <= end_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mseq_reg <= '0;
        else if (state_reg == ST_TRIG)
            mseq_reg <= '0;
        else if (state_reg == ST_MUL && mseq_reg != 4'd9)
            mseq_reg <= mseq_reg + 1'b1;
    end

    logic [1:0] m_axis;
    logic signed [31:0] m_a;
    trig_t m_b;
    assign m_axis = 2'(mseq_reg[3:1]);
    assign m_a = (m_axis > 2'd2) ? 32'sd0 : (mseq_reg[0] ? major_reg[m_axis] : minor_reg[m_axis]);
    assign m_b = mseq_reg[0] ? cos_reg : sin_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(m_a * m_b);
        if (state_reg == ST_MUL && mseq_reg >= 4'd1 && mseq_reg <= 4'd6)
        begin
            if (!mseq_reg[0])
                acc_reg <= acc_reg + 67'(prod_reg);
            else
            begin
                if (mseq_reg != 4'd1)
                    end_reg[2'(mseq_reg[3:1]) - 2'd1] <= sat_val;
                acc_reg <= 67'sd536870912 + 67'(prod_reg);
            end
        end
        if (state_reg == ST_MUL && mseq_reg == 4'd7)
            end_reg[2] <= sat_val;
    end

    assign seg_start_x = prev_reg[0];
    assign seg_start_y = prev_reg[1];
    assign seg_start_z = prev_reg[2];
    assign seg_end_x = end_reg[0];
    assign seg_end_y = end_reg[1];
    assign seg_end_z = end_reg[2];
    assign last_segment = (k_reg == n_reg);

    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> start_stall)
        else $error("Start taken while a segment is pending");
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> (k_reg != '0) && (k_reg <= n_reg))
        else $error("Side index out of range");
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_stall && last_segment |=> state_reg == ST_IDLE)
        else $error("Run did not end after the last segment");

endmodule
